FILE: rtl/mtf_pkg.sv
package mtf_pkg;

  localparam int MTF_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_MOVED     = 3'd1,
    ST_AT_FRONT  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic compare;
    logic shift;
  } ctrl_t;

endpackage

FILE: rtl/mtf_req_if.sv
interface mtf_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [mtf_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: rtl/mtf_rsp_if.sv
interface mtf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mtf_pkg::STATUS_W-1:0]   status;
  logic [mtf_pkg::POS_W-1:0]      found_position;
  logic [mtf_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output found_position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_position, input entry_count,
                  output ready);
endinterface

FILE: rtl/move_to_front_list.sv
// Move-to-front list of up to LIST_DEPTH signed 32-bit values held in a row of cells,
// front at cell 0. An append writes the tail cell; a search finds the entry nearest the
// front equal to the value, moves it to the front and shifts the entries ahead of it back
// one cell. Each item gives one result: status, position of the match before the move
// and the entry count afterwards (position reported modulo 16, count modulo 32). An item
// passes through the transfer into the command register, a compare cycle in which every
// cell registers its match, and an update cycle in which the first match is chosen along
// the hit chain, the cells shift and the result is loaded into the output register.
// The next item is taken in the cycle after the update; a result waiting on the output
// holds only the update of the following item.
module move_to_front_list #(
  parameter int LIST_DEPTH = mtf_pkg::MTF_DEPTH
) (
  input logic       clk,
  input logic       rst,
  mtf_req_if.sink   req,
  mtf_rsp_if.source rsp
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                       state;
  logic                         cmd_q;
  logic [mtf_pkg::DATA_W-1:0]   key_q;
  logic [CNT_W-1:0]             count;

  mtf_pkg::ctrl_t               ctrl;
  logic [LIST_DEPTH:0]          hit;
  logic [LIST_DEPTH-1:0]        first;
  logic [LIST_DEPTH-1:0]        live;
  logic [LIST_DEPTH-1:0]        append_sel;
  logic [mtf_pkg::DATA_W-1:0]   entry [LIST_DEPTH];
  logic [IDX_W-1:0]             pos_term [LIST_DEPTH];
  logic [IDX_W-1:0]             pos;

  logic                         go;
  logic                         full;
  logic                         append_go;
  mtf_pkg::status_t             status_next;
  logic [CNT_W-1:0]             count_next;

  logic                         rsp_valid;
  logic [mtf_pkg::STATUS_W-1:0] rsp_status;
  logic [mtf_pkg::POS_W-1:0]    rsp_pos;
  logic [mtf_pkg::COUNT_W-1:0]  rsp_count;

  logic [IDX_W+mtf_pkg::POS_W-1:0]   pos_wide;
  logic [CNT_W+mtf_pkg::COUNT_W-1:0] count_wide;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid) state <= S_CMP;
        S_CMP:  state <= S_UPD;
        S_UPD:  if (go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q <= req.cmd;
      key_q <= req.value;
    end
  end

  assign go        = (state == S_UPD) && (!rsp_valid || rsp.ready);
  assign full      = (count == CNT_W'(LIST_DEPTH));
  assign append_go = go && (cmd_q == mtf_pkg::CMD_APPEND) && !full;

  assign ctrl.compare = (state == S_CMP);
  assign ctrl.shift   = go && (cmd_q == mtf_pkg::CMD_SEARCH) && hit[LIST_DEPTH] && !first[0];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [mtf_pkg::DATA_W-1:0] prev;

    if (i == 0) begin : g_front
      assign prev = key_q;
    end else begin : g_rest
      assign prev = entry[i-1];
    end

    assign live[i]       = (CNT_W'(i) < count);
    assign append_sel[i] = append_go && (CNT_W'(i) == count);
    assign pos_term[i]   = first[i] ? IDX_W'(i) : '0;

    mtf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (key_q),
      .prev_entry (prev),
      .live       (live[i]),
      .append_sel (append_sel[i]),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .first      (first[i]),
      .entry      (entry[i])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      pos = pos | pos_term[i];
    end
  end

  always_comb begin
    status_next = mtf_pkg::ST_NOT_FOUND;
    count_next  = count;
    if (cmd_q == mtf_pkg::CMD_APPEND) begin
      if (full) begin
        status_next = mtf_pkg::ST_FULL;
      end else begin
        status_next = mtf_pkg::ST_INSERTED;
        count_next  = count + CNT_W'(1);
      end
    end else begin
      priority if (count == '0) begin
        status_next = mtf_pkg::ST_EMPTY;
      end else if (first[0]) begin
        status_next = mtf_pkg::ST_AT_FRONT;
      end else if (hit[LIST_DEPTH]) begin
        status_next = mtf_pkg::ST_MOVED;
      end else begin
        status_next = mtf_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign pos_wide   = {{mtf_pkg::POS_W{1'b0}}, pos};
  assign count_wide = {{mtf_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (go) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp_status <= status_next;
      rsp_pos    <= (status_next == mtf_pkg::ST_MOVED) ? pos_wide[mtf_pkg::POS_W-1:0] : '0;
      rsp_count  <= count_wide[mtf_pkg::COUNT_W-1:0];
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.found_position = rsp_pos;
  assign rsp.entry_count    = rsp_count;

endmodule

FILE: rtl/mtf_cell.sv
module mtf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  mtf_pkg::ctrl_t             ctrl,
  input  logic [mtf_pkg::DATA_W-1:0] key,
  input  logic [mtf_pkg::DATA_W-1:0] prev_entry,
  input  logic                       live,
  input  logic                       append_sel,
  input  logic                       hit_in,
  output logic                       hit_out,
  output logic                       first,
  output logic [mtf_pkg::DATA_W-1:0] entry
);

  logic match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= live && (entry == key);
    end
  end

  // shift back when the first match sits at or behind this cell
  always_ff @(posedge clk) begin
    if (append_sel) begin
      entry <= key;
    end else if (ctrl.shift && !hit_in) begin
      entry <= prev_entry;
    end
  end

  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

endmodule

FILE: rtl/mtf_checker.sv
module mtf_checker #(
  parameter int LIST_DEPTH = mtf_pkg::MTF_DEPTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [mtf_pkg::STATUS_W-1:0] rsp_status,
  input logic [mtf_pkg::POS_W-1:0]    rsp_found_position,
  input logic [mtf_pkg::COUNT_W-1:0]  rsp_entry_count
);

  localparam logic [mtf_pkg::COUNT_W-1:0] FULL_CNT = mtf_pkg::COUNT_W'(LIST_DEPTH % 32);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while an item is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_found_position) && $stable(rsp_entry_count))
    else $error("stalled result changed");

  a_pos_only_on_move: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_found_position != '0) |-> rsp_status == mtf_pkg::ST_MOVED)
    else $error("position reported without a move");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == mtf_pkg::ST_FULL) |-> rsp_entry_count == FULL_CNT)
    else $error("full status with wrong count");

endmodule

bind move_to_front_list mtf_checker #(.LIST_DEPTH(LIST_DEPTH)) u_mtf_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_entry_count    (rsp.entry_count)
);
